### hw/rtl/score_glyph_pixel_renderer_core_macros.svh
// Assertion macros used by the renderer core.
`ifndef SCORE_GLYPH_PIXEL_RENDERER_CORE_MACROS_SVH
`define SCORE_GLYPH_PIXEL_RENDERER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define SGPR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`define SGPR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`define SGPR_ASSERT_LAT(lbl, clk_s, rst_s, ante, cons, lat, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> ##(lat) (cons)) \
        else $error(msg);

`else

`define SGPR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define SGPR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`define SGPR_ASSERT_LAT(lbl, clk_s, rst_s, ante, cons, lat, msg)

`endif

`endif

### hw/rtl/sgpr_pkg.sv
`timescale 1ns / 1ps

package sgpr_pkg;

    localparam int MAX_DIGITS    = 3;
    localparam int MAX_ARROWS    = 3;

    localparam int X_W           = 6;
    localparam int Y_W           = 5;
    localparam int SCORE_W       = 10;
    localparam int COUNT_W       = 2;
    localparam int COLOR_W       = 16;
    localparam int CFG_IDX_W     = 2;

    localparam int GLYPH_W       = 5;
    localparam int GLYPH_H       = 7;
    localparam int GLYPH_PITCH   = 6;
    localparam int ARW_W         = 9;
    localparam int ARW_H         = 7;
    localparam int ARW_PITCH     = 10;
    localparam int DIGIT_ROW     = 15;
    localparam int ARROW_ROW     = 3;
    localparam int LEFT_MID      = 16;
    localparam int RIGHT_MID     = 48;
    localparam int DIVIDER_COL   = 32;
    localparam int DIVIDER_FIRST = 4;
    localparam int DIVIDER_LAST  = 28;
    localparam int DIVIDER_STEP  = 4;
    localparam int GLYPH_COUNT   = 10;
    localparam int PIPE_DEPTH    = 3;

    localparam int SCORE_MAX     = 10 ** MAX_DIGITS - 1;
    localparam int DCNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int ACNT_W        = $clog2(MAX_ARROWS + 1);
    localparam int DSLOT_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int ASLOT_W       = (MAX_ARROWS > 1) ? $clog2(MAX_ARROWS) : 1;
    localparam int DDX_W         = $clog2(GLYPH_PITCH * MAX_DIGITS - 1);
    localparam int ADX_W         = $clog2(ARW_PITCH * MAX_ARROWS - 1);
    localparam int GCOL_W        = $clog2(GLYPH_W);
    localparam int ACOL_W        = $clog2(ARW_W);
    localparam int ROW_W         = $clog2((GLYPH_H > ARW_H) ? GLYPH_H : ARW_H);

    localparam logic [COLOR_W-1:0] WHITE565 = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCORE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCORE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVE_LEFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd3;

    localparam logic [GLYPH_W-1:0] GLYPH_ROWS [GLYPH_COUNT][GLYPH_H] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
    };

    // Right-pointing arrow, MSB is the leftmost column
    localparam logic [ARW_W-1:0] ARROW_ROWS [ARW_H] = '{
        9'h008, 9'h00C, 9'h1FE, 9'h1FF, 9'h1FE, 9'h00C, 9'h008
    };

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [X_W-1:0] pixel_x;
        logic [Y_W-1:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic               lit;
        logic [COLOR_W-1:0] pixel_color;
    } out_item_t;

    typedef struct packed {
        digit_t [MAX_DIGITS-1:0] digits;
        logic [DCNT_W-1:0]       count;
        logic [X_W-1:0]          start;
    } score_layout_t;

    typedef struct packed {
        score_layout_t       left;
        score_layout_t       right;
        logic                mirror;
        logic [ACNT_W-1:0]   arrows;
        logic [X_W-1:0]      arrow_start;
    } layout_t;

    typedef struct packed {
        logic             div_hit;
        logic             l_hit;
        logic [DDX_W-1:0] l_dx;
        logic             r_hit;
        logic [DDX_W-1:0] r_dx;
        logic             a_hit;
        logic [ADX_W-1:0] a_dx;
        logic [ROW_W-1:0] drow;
        logic [ROW_W-1:0] arow;
    } stage1_t;

    typedef struct packed {
        logic              div_hit;
        logic              l_hit;
        digit_t            l_code;
        logic [GCOL_W-1:0] l_col;
        logic              r_hit;
        digit_t            r_code;
        logic [GCOL_W-1:0] r_col;
        logic              a_hit;
        logic [ACOL_W-1:0] a_col;
        logic [ROW_W-1:0]  drow;
        logic [ROW_W-1:0]  arow;
    } stage2_t;

    function automatic score_layout_t score_layout(input logic [SCORE_W-1:0] score,
                                                   input int mid);
        score_layout_t lay;
        int            rem;
        int            p;
        int            q;
        int            n;
        digit_t        d [MAX_DIGITS];
        rem = (int'(score) > SCORE_MAX) ? SCORE_MAX : int'(score);
        for (int i = MAX_DIGITS - 1; i >= 0; i--)
        begin
            p = 1;
            for (int j = 0; j < i; j++)
            begin
                p = p * 10;
            end
            q = 0;
            for (int k = 1; k < 10; k++)
            begin
                if (rem >= k * p)
                begin
                    q = k;
                end
            end
            rem  = rem - q * p;
            d[i] = 4'(q);
        end
        n = 1;
        for (int i = 1; i < MAX_DIGITS; i++)
        begin
            if (d[i] != '0)
            begin
                n = i + 1;
            end
        end
        lay.digits = '0;
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (j < n)
            begin
                lay.digits[j] = d[n - 1 - j];
            end
        end
        lay.count = DCNT_W'(n);
        lay.start = X_W'(mid - (GLYPH_PITCH / 2) * n);
        return lay;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_row(input digit_t code,
                                                     input logic [ROW_W-1:0] row);
        logic [GLYPH_W-1:0] bits;
        bits = '0;
        if (int'(code) < GLYPH_COUNT && int'(row) < GLYPH_H)
        begin
            bits = GLYPH_ROWS[code][row];
        end
        return bits;
    endfunction

    function automatic logic [ARW_W-1:0] arrow_row(input logic [ROW_W-1:0] row);
        logic [ARW_W-1:0] bits;
        bits = '0;
        if (int'(row) < ARW_H)
        begin
            bits = ARROW_ROWS[row];
        end
        return bits;
    endfunction

endpackage

### hw/rtl/sgpr_cfg.sv
`timescale 1ns / 1ps

module sgpr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [sgpr_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [sgpr_pkg::SCORE_W-1:0]   wr_data,
    output sgpr_pkg::layout_t              layout
);
    import sgpr_pkg::*;

    score_layout_t        left_reg;
    score_layout_t        right_reg;
    logic                 serve_left_reg;
    logic [COUNT_W-1:0]   server_count_reg;
    logic [ACNT_W-1:0]    arrows_capped;
    int                   mid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg         <= score_layout('0, LEFT_MID);
            right_reg        <= score_layout('0, RIGHT_MID);
            serve_left_reg   <= 1'b0;
            server_count_reg <= COUNT_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_LEFT_SCORE:   left_reg         <= score_layout(wr_data, LEFT_MID);
                CFG_RIGHT_SCORE:  right_reg        <= score_layout(wr_data, RIGHT_MID);
                CFG_SERVE_LEFT:   serve_left_reg   <= wr_data[0];
                CFG_SERVER_COUNT: server_count_reg <= wr_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(server_count_reg) > MAX_ARROWS)
        begin
            arrows_capped = ACNT_W'(MAX_ARROWS);
        end
        else
        begin
            arrows_capped = ACNT_W'(server_count_reg);
        end
        mid = serve_left_reg ? LEFT_MID : RIGHT_MID;
        layout.left        = left_reg;
        layout.right       = right_reg;
        layout.mirror      = serve_left_reg;
        layout.arrows      = arrows_capped;
        layout.arrow_start = X_W'(mid - (ARW_PITCH / 2) * int'(arrows_capped));
    end

endmodule

### hw/rtl/sgpr_locate.sv
`timescale 1ns / 1ps

module sgpr_locate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sgpr_pkg::in_item_t  in_item,
    input  sgpr_pkg::layout_t   layout,
    output logic                s2_valid,
    output sgpr_pkg::stage2_t   s2
);
    import sgpr_pkg::*;

    logic           s1_valid_reg;
    stage1_t        s1_reg;
    stage1_t        s1_next;
    logic           s2_valid_reg;
    stage2_t        s2_reg;
    stage2_t        s2_next;

    logic [X_W-1:0] l_dx_full;
    logic [X_W-1:0] r_dx_full;
    logic [X_W-1:0] a_dx_full;
    logic [Y_W-1:0] py;
    logic [X_W-1:0] px;
    logic           drow_ok;
    logic           arow_ok;

    logic [DSLOT_W-1:0] l_slot;
    logic [DSLOT_W-1:0] r_slot;
    logic [ASLOT_W-1:0] a_slot;
    logic [DDX_W-1:0]   l_col;
    logic [DDX_W-1:0]   r_col;
    logic [ADX_W-1:0]   a_col;

    function automatic logic [DSLOT_W-1:0] digit_slot(input logic [DDX_W-1:0] dx);
        logic [DSLOT_W-1:0] slot;
        slot = '0;
        for (int k = 1; k < MAX_DIGITS; k++)
        begin
            if (int'(dx) >= k * GLYPH_PITCH)
            begin
                slot = DSLOT_W'(k);
            end
        end
        return slot;
    endfunction

    function automatic logic [ASLOT_W-1:0] arrow_slot(input logic [ADX_W-1:0] dx);
        logic [ASLOT_W-1:0] slot;
        slot = '0;
        for (int k = 1; k < MAX_ARROWS; k++)
        begin
            if (int'(dx) >= k * ARW_PITCH)
            begin
                slot = ASLOT_W'(k);
            end
        end
        return slot;
    endfunction

    // Stage one: band and span tests, offsets into each group
    always_comb
    begin
        px        = in_item.pixel_x;
        py        = in_item.pixel_y;
        drow_ok   = (py >= Y_W'(DIGIT_ROW)) && (py < Y_W'(DIGIT_ROW + GLYPH_H));
        arow_ok   = (py >= Y_W'(ARROW_ROW)) && (py < Y_W'(ARROW_ROW + ARW_H));
        l_dx_full = px - layout.left.start;
        r_dx_full = px - layout.right.start;
        a_dx_full = px - layout.arrow_start;

        s1_next.div_hit = (px == X_W'(DIVIDER_COL))
                        && (py >= Y_W'(DIVIDER_FIRST)) && (py <= Y_W'(DIVIDER_LAST))
                        && ((py % DIVIDER_STEP) == '0);
        s1_next.l_hit   = drow_ok && (px >= layout.left.start)
                        && (l_dx_full < X_W'(GLYPH_PITCH * int'(layout.left.count) - 1));
        s1_next.r_hit   = drow_ok && (px >= layout.right.start)
                        && (r_dx_full < X_W'(GLYPH_PITCH * int'(layout.right.count) - 1));
        s1_next.a_hit   = arow_ok && (layout.arrows != '0) && (px >= layout.arrow_start)
                        && (a_dx_full < X_W'(ARW_PITCH * int'(layout.arrows) - 1));
        s1_next.l_dx    = l_dx_full[DDX_W-1:0];
        s1_next.r_dx    = r_dx_full[DDX_W-1:0];
        s1_next.a_dx    = a_dx_full[ADX_W-1:0];
        s1_next.drow    = ROW_W'(py - Y_W'(DIGIT_ROW));
        s1_next.arow    = ROW_W'(py - Y_W'(ARROW_ROW));
    end

    // Stage two: slot within group, column within glyph, digit code
    always_comb
    begin
        l_slot = digit_slot(s1_reg.l_dx);
        r_slot = digit_slot(s1_reg.r_dx);
        a_slot = arrow_slot(s1_reg.a_dx);
        l_col  = DDX_W'(int'(s1_reg.l_dx) - GLYPH_PITCH * int'(l_slot));
        r_col  = DDX_W'(int'(s1_reg.r_dx) - GLYPH_PITCH * int'(r_slot));
        a_col  = ADX_W'(int'(s1_reg.a_dx) - ARW_PITCH * int'(a_slot));

        s2_next.div_hit = s1_reg.div_hit;
        s2_next.l_hit   = s1_reg.l_hit && (l_col < DDX_W'(GLYPH_W));
        s2_next.r_hit   = s1_reg.r_hit && (r_col < DDX_W'(GLYPH_W));
        s2_next.a_hit   = s1_reg.a_hit && (a_col < ADX_W'(ARW_W));
        s2_next.l_code  = layout.left.digits[l_slot];
        s2_next.r_code  = layout.right.digits[r_slot];
        s2_next.l_col   = l_col[GCOL_W-1:0];
        s2_next.r_col   = r_col[GCOL_W-1:0];
        s2_next.a_col   = a_col[ACOL_W-1:0];
        s2_next.drow    = s1_reg.drow;
        s2_next.arow    = s1_reg.arow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

### hw/rtl/sgpr_raster.sv
`timescale 1ns / 1ps

module sgpr_raster (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s2_valid,
    input  sgpr_pkg::stage2_t   s2,
    input  logic                mirror,
    output logic                done,
    output sgpr_pkg::out_item_t result
);
    import sgpr_pkg::*;

    logic               done_reg;
    out_item_t          result_reg;
    out_item_t          result_next;
    logic [GLYPH_W-1:0] l_bits;
    logic [GLYPH_W-1:0] r_bits;
    logic [ARW_W-1:0]   a_bits;
    logic [GCOL_W-1:0]  l_shift;
    logic [GCOL_W-1:0]  r_shift;
    logic [ACOL_W-1:0]  a_shift;
    logic               lit_next;

    always_comb
    begin
        l_bits  = glyph_row(s2.l_code, s2.drow);
        r_bits  = glyph_row(s2.r_code, s2.drow);
        a_bits  = arrow_row(s2.arow);
        l_shift = GCOL_W'(GLYPH_W - 1) - s2.l_col;
        r_shift = GCOL_W'(GLYPH_W - 1) - s2.r_col;
        a_shift = mirror ? s2.a_col : (ACOL_W'(ARW_W - 1) - s2.a_col);

        lit_next = s2.div_hit
                 || (s2.l_hit && l_bits[l_shift])
                 || (s2.r_hit && r_bits[r_shift])
                 || (s2.a_hit && a_bits[a_shift]);

        result_next.lit         = lit_next;
        result_next.pixel_color = lit_next ? WHITE565 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/score_glyph_pixel_renderer_core.sv
// Scoreboard pixel renderer for a 64x32 panel. Present one pixel coordinate per
// clock with start; done pulses for exactly one cycle per transaction, once it
// has passed the s1, s2 and result registers, carrying lit and its RGB565 colour.
// Results come out in order and cannot be held off: sample them when done is
// high. Throughput is one pixel every cycle, set by a three-stage pipeline (span
// test, slot and column decode, font lookup). busy is a register that reset sets
// and every clock clears; from then on every start is taken. Layout registers
// are written through the cfg channel, take effect on the next cycle, and must
// be written only when no pixel is in flight.
`timescale 1ns / 1ps
`include "score_glyph_pixel_renderer_core_macros.svh"

module score_glyph_pixel_renderer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sgpr_pkg::in_item_t             pixel,
    output logic                           done,
    output sgpr_pkg::out_item_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sgpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgpr_pkg::SCORE_W-1:0]   cfg_data
);
    import sgpr_pkg::*;

    logic    busy_reg;
    logic    accept;
    logic    wr_en;
    layout_t layout;
    logic    s2_valid;
    stage2_t s2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign accept    = start && !busy_reg;
    assign wr_en     = cfg_valid && cfg_ready;

    sgpr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .layout   (layout)
    );

    sgpr_locate u_locate (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_item  (pixel),
        .layout   (layout),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    sgpr_raster u_raster (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid),
        .s2       (s2),
        .mirror   (layout.mirror),
        .done     (done),
        .result   (result)
    );

    `SGPR_ASSERT_LAT(a_result_latency, clk, rst_n, accept, done, PIPE_DEPTH, "transaction without result")
    `SGPR_ASSERT_IMP(a_no_stray_result, clk, rst_n, done, $past(accept, PIPE_DEPTH), "result without transaction")
    `SGPR_ASSERT_NEXT(a_busy_settles, clk, rst_n, !busy, !busy, "busy raised after reset")

endmodule
